/* sv/spmv_pkg.sv */
`timescale 1ns / 1ps

package spmv_pkg;

    localparam int DEF_MAX_ROWS = 1024;
    localparam int DEF_MAX_COLS = 1024;

    localparam int IDX_W     = 10;
    localparam int VAL_W     = 32;
    localparam int FRAC_W    = 16;
    localparam int SUM_W     = 48;
    localparam int DIM_W     = 11;
    localparam int THR_W     = 31;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 31;

    localparam logic [DIM_W-1:0] RST_NUM_ROWS = 11'd1024;
    localparam logic [DIM_W-1:0] RST_NUM_COLS = 11'd1024;

    typedef enum logic [1:0] {
        CMD_LOAD_X     = 2'd0,
        CMD_ACCUM      = 2'd1,
        CMD_READ_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_DROP  = 2'd2,
        ST_SAT   = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_ROWS       = 2'd0,
        CFG_NUM_COLS       = 2'd1,
        CFG_DROP_THRESHOLD = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_MUL   = 2'd2,
        S_ACC   = 2'd3
    } t_state;

    typedef struct packed {
        logic [1:0]              command;
        logic [IDX_W-1:0]        row_index;
        logic [IDX_W-1:0]        col_index;
        logic signed [VAL_W-1:0] operand_value;
    } t_req;

    typedef struct packed {
        logic signed [SUM_W-1:0] row_sum;
        logic [1:0]              status;
    } t_result;

endpackage

/* sv/spmv_ram.sv */
`timescale 1ns / 1ps

module spmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/spmv_mac.sv */
`timescale 1ns / 1ps

module spmv_mac (
    input  logic                              i_clk,
    input  logic                              i_prod_en,
    input  logic signed [spmv_pkg::VAL_W-1:0] i_a,
    input  logic signed [spmv_pkg::VAL_W-1:0] i_x,
    input  logic signed [spmv_pkg::SUM_W-1:0] i_sum,
    output logic signed [spmv_pkg::SUM_W-1:0] o_sum,
    output logic                              o_sat
);

    import spmv_pkg::*;

    logic signed [2*VAL_W-1:0] w_prod;
    logic signed [SUM_W-1:0]   r_prod;
    logic [SUM_W:0]            w_acc;

    assign w_prod = i_a * i_x;

    // Dropping the low fraction bits of a two's complement product floors it.
    always_ff @(posedge i_clk) begin
        if (i_prod_en) begin
            r_prod <= w_prod[2*VAL_W-1:FRAC_W];
        end
    end

    assign w_acc = {i_sum[SUM_W-1], i_sum} + {r_prod[SUM_W-1], r_prod};
    assign o_sat = w_acc[SUM_W] ^ w_acc[SUM_W-1];

    always_comb begin
        if (!o_sat) begin
            o_sum = w_acc[SUM_W-1:0];
        end else if (w_acc[SUM_W]) begin
            o_sum = {1'b1, {(SUM_W-1){1'b0}}};
        end else begin
            o_sum = {1'b0, {(SUM_W-1){1'b1}}};
        end
    end

endmodule

/* sv/sparse_coo_matvec_accumulator.sv */
`timescale 1ns / 1ps

// Sparse matrix-vector accumulator for coordinate-format nonzeros. A request is
// taken when start is high and busy is low; its single result appears on
// o_result for exactly one cycle, marked by o_done, once the request has passed
// through S_MUL, S_ACC and the result register, and is captured while o_done is high
// because the block cannot be held off. No new request is taken until the last one
// is through: the x and row-sum memories are read at acceptance, the product is
// registered in S_MUL, and the saturating add and the write-back to the row-sum
// memory take place in S_ACC.
// After reset the row-sum memory is cleared one entry per cycle, which keeps busy
// high until the last entry is cleared; configuration writes are taken at any time.

module sparse_coo_matvec_accumulator #(
    parameter int MAX_ROWS = spmv_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = spmv_pkg::DEF_MAX_COLS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  spmv_pkg::t_req                    i_req,
    output logic                              busy,
    output logic                              o_done,
    output spmv_pkg::t_result                 o_result,
    input  logic                              i_cfg_we,
    input  logic [spmv_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [spmv_pkg::CFG_DAT_W-1:0]    i_cfg_data
);

    import spmv_pkg::*;

    localparam int RAW = $clog2(MAX_ROWS);
    localparam int CAW = $clog2(MAX_COLS);
    localparam logic [16:0] ROW_LIMIT = 17'(MAX_ROWS);
    localparam logic [16:0] COL_LIMIT = 17'(MAX_COLS);
    localparam logic [RAW-1:0] LAST_ROW = RAW'(MAX_ROWS - 1);

    t_state             r_state, n_state;
    logic [RAW-1:0]     r_clr_addr;
    t_req               r_req;
    logic               r_row_ok, r_col_ok, r_drop;
    logic [DIM_W-1:0]   r_num_rows, r_num_cols;
    logic [THR_W-1:0]   r_thr;
    logic               r_done, n_done;
    t_result            r_result, n_result;

    logic               w_accept;
    logic               w_row_ok, w_col_ok, w_drop;
    logic [VAL_W-1:0]   w_val_u, w_mag;
    logic               w_x_we, w_row_we, w_prod_en;
    logic [RAW-1:0]     w_row_waddr;
    logic [SUM_W-1:0]   w_row_wdata;
    logic [VAL_W-1:0]   w_x_rdata;
    logic [SUM_W-1:0]   w_row_rdata;
    logic [SUM_W-1:0]   w_mac_sum;
    logic               w_mac_sat;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    assign w_row_ok = ({1'b0, i_req.row_index} < r_num_rows)
                   && (17'(i_req.row_index) < ROW_LIMIT);
    assign w_col_ok = ({1'b0, i_req.col_index} < r_num_cols)
                   && (17'(i_req.col_index) < COL_LIMIT);

    // The magnitude of the most negative operand is 2^31, which no threshold reaches.
    assign w_val_u = i_req.operand_value;
    assign w_mag   = w_val_u[VAL_W-1] ? (~w_val_u + 32'd1) : w_val_u;
    assign w_drop  = (w_mag <= {1'b0, r_thr});

    spmv_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_COLS)
    ) u_x_ram (
        .i_clk   (i_clk),
        .i_we    (w_x_we),
        .i_waddr (CAW'(r_req.col_index)),
        .i_wdata (r_req.operand_value),
        .i_re    (w_accept),
        .i_raddr (CAW'(i_req.col_index)),
        .o_rdata (w_x_rdata)
    );

    spmv_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_ROWS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (w_row_we),
        .i_waddr (w_row_waddr),
        .i_wdata (w_row_wdata),
        .i_re    (w_accept),
        .i_raddr (RAW'(i_req.row_index)),
        .o_rdata (w_row_rdata)
    );

    spmv_mac u_mac (
        .i_clk     (i_clk),
        .i_prod_en (w_prod_en),
        .i_a       (r_req.operand_value),
        .i_x       (w_x_rdata),
        .i_sum     (w_row_rdata),
        .o_sum     (w_mac_sum),
        .o_sat     (w_mac_sat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_done     <= 1'b0;
            r_num_rows <= RST_NUM_ROWS;
            r_num_cols <= RST_NUM_COLS;
            r_thr      <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NUM_ROWS:       r_num_rows <= i_cfg_data[DIM_W-1:0];
                    CFG_NUM_COLS:       r_num_cols <= i_cfg_data[DIM_W-1:0];
                    CFG_DROP_THRESHOLD: r_thr      <= i_cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req    <= i_req;
            r_row_ok <= w_row_ok;
            r_col_ok <= w_col_ok;
            r_drop   <= w_drop;
        end
        r_result <= n_result;
    end

    always_comb begin
        n_state          = r_state;
        n_done           = 1'b0;
        n_result.row_sum = '0;
        n_result.status  = ST_OK;
        w_x_we           = 1'b0;
        w_row_we         = 1'b0;
        w_row_waddr      = RAW'(r_req.row_index);
        w_row_wdata      = '0;
        w_prod_en        = 1'b0;
        case (r_state)
            S_CLEAR: begin
                w_row_we    = 1'b1;
                w_row_waddr = r_clr_addr;
                if (r_clr_addr == LAST_ROW) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                w_prod_en = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                case (t_cmd'(r_req.command))
                    CMD_LOAD_X: begin
                        if (r_col_ok) begin
                            w_x_we = 1'b1;
                        end else begin
                            n_result.status = ST_RANGE;
                        end
                    end
                    CMD_ACCUM: begin
                        if (!(r_row_ok && r_col_ok)) begin
                            n_result.status = ST_RANGE;
                        end else if (r_drop) begin
                            n_result.status = ST_DROP;
                        end else begin
                            w_row_we    = 1'b1;
                            w_row_wdata = w_mac_sum;
                            n_result.status = w_mac_sat ? ST_SAT : ST_OK;
                        end
                    end
                    CMD_READ_CLEAR: begin
                        if (r_row_ok) begin
                            n_result.row_sum = w_row_rdata;
                            w_row_we         = 1'b1;
                        end else begin
                            n_result.status = ST_RANGE;
                        end
                    end
                    default: begin
                        n_result.status = ST_RANGE;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    a_done_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_ACC))
        else $error("result strobe without a finished request");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_MUL))
        else $error("accepted request did not start");

    a_done_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while still busy");

    a_err_zero_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != ST_OK) |-> (o_result.row_sum == '0))
        else $error("nonzero row sum with a non-ok status");

    a_row_write_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_row_we |-> (r_state == S_CLEAR || (r_state == S_ACC && r_row_ok)))
        else $error("row sum written outside clear pass or valid request");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
    import spmv_pkg::*;

    localparam int                 CLK_PERIOD  = 20;
    localparam int                 STALL_LIMIT = 4000;
    localparam logic [1:0]         CMD_UNUSED  = 2'd3;
    localparam logic signed [63:0] SUM_MAX     = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] SUM_MIN     = -SUM_MAX - 64'sd1;
    localparam logic [VAL_W-1:0]   VAL_MIN     = 32'h8000_0000;
    localparam logic [VAL_W-1:0]   VAL_MAX     = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0]   VAL_ONE     = 32'h0001_0000;
    localparam logic [VAL_W-1:0]   VAL_HALF_NEG = 32'hFFFF_8000;
    localparam logic [VAL_W-1:0]   VAL_LSB_NEG = 32'hFFFF_FFFF;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    t_req                 i_req;
    logic                 busy;
    logic                 o_done;
    t_result              o_result;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    // Local copy of the block's registers and memories.
    logic [DIM_W-1:0]        rows_in_use;
    logic [DIM_W-1:0]        cols_in_use;
    logic [THR_W-1:0]        drop_level;
    logic signed [VAL_W-1:0] x_elems [DEF_MAX_COLS];
    bit                      x_written [DEF_MAX_COLS];
    logic signed [SUM_W-1:0] row_totals [DEF_MAX_ROWS];

    t_result pending_results[$];
    int      mismatch_count = 0;
    int      idle_cycles = 0;

    sparse_coo_matvec_accumulator uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req      (i_req),
        .busy       (busy),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic bit row_valid(logic [IDX_W-1:0] r);
        return ({1'b0, r} < rows_in_use) && (32'(r) < DEF_MAX_ROWS);
    endfunction

    function automatic bit col_valid(logic [IDX_W-1:0] c);
        return ({1'b0, c} < cols_in_use) && (32'(c) < DEF_MAX_COLS);
    endfunction

    function automatic t_result predict_row_result(t_req r);
        t_result                 res;
        logic signed [VAL_W-1:0] entry;
        logic [VAL_W-1:0]        mag;
        logic signed [63:0]      prod;
        logic signed [63:0]      total;
        res = '0;
        res.status = ST_OK;
        entry = r.operand_value;
        case (r.command)
            CMD_LOAD_X: begin
                if (col_valid(r.col_index)) begin
                    x_elems[r.col_index] = entry;
                    x_written[r.col_index] = 1'b1;
                end else begin
                    res.status = ST_RANGE;
                end
            end
            CMD_ACCUM: begin
                // The most negative value has magnitude 2^31, which fits unsigned.
                mag = entry[VAL_W-1] ? -entry : entry;
                if (!row_valid(r.row_index) || !col_valid(r.col_index)) begin
                    res.status = ST_RANGE;
                end else if (mag <= {1'b0, drop_level}) begin
                    res.status = ST_DROP;
                end else begin
                    prod = entry * x_elems[r.col_index];
                    total = row_totals[r.row_index] + (prod >>> FRAC_W);
                    if (total > SUM_MAX) begin
                        total = SUM_MAX;
                        res.status = ST_SAT;
                    end else if (total < SUM_MIN) begin
                        total = SUM_MIN;
                        res.status = ST_SAT;
                    end
                    row_totals[r.row_index] = total[SUM_W-1:0];
                end
            end
            CMD_READ_CLEAR: begin
                if (row_valid(r.row_index)) begin
                    res.row_sum = row_totals[r.row_index];
                    row_totals[r.row_index] = '0;
                end else begin
                    res.status = ST_RANGE;
                end
            end
            default: res.status = ST_RANGE;
        endcase
        return res;
    endfunction

    function automatic t_req make_req(logic [1:0] cmd, logic [IDX_W-1:0] row,
                                      logic [IDX_W-1:0] col, logic [VAL_W-1:0] val);
        t_req r;
        r.command = cmd;
        r.row_index = row;
        r.col_index = col;
        r.operand_value = val;
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with start still high, so back-to-back requests need no extra step.
    task automatic send_request(t_req r, int max_gap);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(predict_row_result(r));
        @(negedge i_clk);
    endtask

    task automatic issue(logic [1:0] cmd, int row, int col, logic [VAL_W-1:0] val);
        send_request(make_req(cmd, IDX_W'(row), IDX_W'(col), val), 3);
    endtask

    task automatic wait_results_drained();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic set_config(logic [DIM_W-1:0] rows, logic [DIM_W-1:0] cols,
                              logic [THR_W-1:0] thr);
        wait_results_drained();
        repeat (3) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_NUM_ROWS;
        i_cfg_data <= CFG_DAT_W'(rows);
        @(negedge i_clk);
        i_cfg_index <= CFG_NUM_COLS;
        i_cfg_data <= CFG_DAT_W'(cols);
        @(negedge i_clk);
        i_cfg_index <= CFG_DROP_THRESHOLD;
        i_cfg_data <= CFG_DAT_W'(thr);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        rows_in_use = rows;
        cols_in_use = cols;
        drop_level = thr;
    endtask

    task automatic test_reset_clears_sums();
        issue(CMD_READ_CLEAR, 0, 0, '0);
        issue(CMD_READ_CLEAR, 1023, 1023, '0);
    endtask

    task automatic test_saturation_and_rounding();
        issue(CMD_LOAD_X, 0, 0, VAL_MIN);
        issue(CMD_LOAD_X, 0, 1023, VAL_MAX);
        issue(CMD_LOAD_X, 0, 1, VAL_ONE);
        // Two products of 2^46 overflow the positive bound.
        issue(CMD_ACCUM, 0, 0, VAL_MIN);
        issue(CMD_ACCUM, 0, 0, VAL_MIN);
        issue(CMD_READ_CLEAR, 0, 0, '0);
        repeat (3) issue(CMD_ACCUM, 1023, 1023, VAL_MIN);
        issue(CMD_READ_CLEAR, 1023, 0, '0);
        issue(CMD_ACCUM, 2, 1, '0);
        issue(CMD_ACCUM, 2, 1, VAL_HALF_NEG);
        // Truncation of negative products rounds toward minus infinity.
        issue(CMD_ACCUM, 2, 1023, VAL_LSB_NEG);
        issue(CMD_ACCUM, 2, 1023, 32'h0000_0001);
        issue(CMD_READ_CLEAR, 2, 0, '0);
        issue(CMD_UNUSED, 3, 3, VAL_MAX);
    endtask

    task automatic test_range_and_drop();
        set_config(11'd1, 11'd1, VAL_MAX[THR_W-1:0]);
        issue(CMD_ACCUM, 0, 0, VAL_MAX);
        issue(CMD_ACCUM, 0, 0, VAL_MIN);
        issue(CMD_ACCUM, 1, 0, VAL_MIN);
        issue(CMD_LOAD_X, 0, 1, VAL_ONE);
        issue(CMD_READ_CLEAR, 1, 0, '0);
        issue(CMD_READ_CLEAR, 0, 0, '0);
        // With zero rows and columns every index is out of range.
        set_config(11'd0, 11'd0, 31'd5);
        issue(CMD_LOAD_X, 0, 0, VAL_ONE);
        issue(CMD_ACCUM, 0, 0, VAL_MIN);
        issue(CMD_READ_CLEAR, 0, 0, '0);
    endtask

    task automatic test_random_traffic(int count, logic [DIM_W-1:0] rows,
                                       logic [DIM_W-1:0] cols, logic [THR_W-1:0] thr);
        int               pick;
        logic [1:0]       cmd;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [VAL_W-1:0] val;
        set_config(rows, cols, thr);
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) wait_results_drained();
            pick = $urandom_range(0, 99);
            cmd = (pick < 25) ? CMD_LOAD_X : (pick < 75) ? CMD_ACCUM :
                  (pick < 95) ? CMD_READ_CLEAR : CMD_UNUSED;
            row = ($urandom_range(0, 9) < 8) ? IDX_W'($urandom_range(0, 31))
                                              : IDX_W'($urandom_range(0, 1023));
            col = ($urandom_range(0, 9) < 8) ? IDX_W'($urandom_range(0, 31))
                                              : IDX_W'($urandom_range(0, 1023));
            case ($urandom_range(0, 9))
                0, 1, 2, 3: val = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
                4, 5:       val = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
                6, 7:       val = $urandom();
                8: begin
                    case ($urandom_range(0, 4))
                        0: val = VAL_MIN;
                        1: val = VAL_MAX;
                        2: val = '0;
                        3: val = 32'h0000_0001;
                        default: val = VAL_LSB_NEG;
                    endcase
                end
                default: begin
                    // Land right around the drop threshold.
                    val = 32'(drop_level) + $urandom_range(0, 2) - 1;
                    if ($urandom_range(0, 1) == 1) val = -val;
                end
            endcase
            // Never multiply by an x element that was not loaded yet.
            if (cmd == CMD_ACCUM && !x_written[col]) cmd = CMD_LOAD_X;
            send_request(make_req(cmd, row, col, val), ((i / 32) % 3 == 0) ? 0 : 3);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("result with no request pending: row_sum %0d status %0d",
                       o_result.row_sum, o_result.status);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.row_sum !== want.row_sum) begin
                    $error("row_sum: expected %0d, actual %0d", want.row_sum, o_result.row_sum);
                    mismatch_count++;
                end
                if (o_result.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_result.status);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        rows_in_use = RST_NUM_ROWS;
        cols_in_use = RST_NUM_COLS;
        drop_level = '0;
        for (int i = 0; i < DEF_MAX_COLS; i++) begin
            x_elems[i] = '0;
            x_written[i] = 1'b0;
        end
        for (int i = 0; i < DEF_MAX_ROWS; i++) row_totals[i] = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_clears_sums();
        test_saturation_and_rounding();
        test_range_and_drop();
        test_random_traffic(160, 11'd1024, 11'd1024, 31'd0);
        test_random_traffic(150, 11'd2047, 11'd2047, 31'($urandom_range(0, 32'h0002_0000)));
        test_random_traffic(120, 11'd20, 11'd28, 31'h0000_0100);
        test_random_traffic(120, 11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024)),
                            31'($urandom_range(0, 32'h0001_0000)));

        wait_results_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
